@@ rtl/core/audio_tone_volume_control_mapper_assert.svh @@
// Assertion macros for the audio tone and volume control mapper.
`ifndef AUDIO_TONE_VOLUME_CONTROL_MAPPER_ASSERT_SVH
`define AUDIO_TONE_VOLUME_CONTROL_MAPPER_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a property on every rising clock edge outside reset.
`define ATVC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check that a condition leads to another one in the next cycle.
`define ATVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ATVC_ASSERT(label, prop, msg)
`define ATVC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/core/atvc_pkg.sv @@
// Types and constants shared by the audio tone and volume control mapper.
package atvc_pkg;

  typedef enum logic [1:0] {
    ACT_STEP_UP    = 2'd0,
    ACT_STEP_DOWN  = 2'd1,
    ACT_SET_VOLUME = 2'd2,
    ACT_SET_MUTE   = 2'd3
  } atvc_action_e;

  typedef enum logic [2:0] {
    SEL_BASS        = 3'd0,
    SEL_TREBLE      = 3'd1,
    SEL_BASS_FREQ   = 3'd2,
    SEL_TREBLE_FREQ = 3'd3,
    SEL_BALANCE     = 3'd4
  } atvc_sel_e;

  typedef enum logic [2:0] {
    UPD_NONE      = 3'd0,
    UPD_MUTE      = 3'd1,
    UPD_TONE_GAIN = 3'd2,
    UPD_TONE_FREQ = 3'd3,
    UPD_VOLUME    = 3'd4
  } atvc_update_e;

  // Tone levels are held as codec codes: level = 120 - 15 * code.
  localparam logic [3:0] ToneCodeTop       = 4'd15;
  localparam logic [3:0] ToneCodeBottom    = 4'd0;
  localparam logic [3:0] BassCodeReset     = 4'd4;
  localparam logic [3:0] TrebleCodeReset   = 4'd6;

  localparam logic [1:0] FreqTop           = 2'd3;
  localparam logic [1:0] FreqBottom        = 2'd0;
  localparam logic [1:0] BassFreqReset     = 2'd1;
  localparam logic [1:0] TrebleFreqReset   = 2'd0;

  localparam logic signed [10:0] BalTop    = 11'sd400;
  localparam logic signed [10:0] BalBottom = -11'sd400;
  localparam logic [9:0]  BalKneeLow       = 10'd100;
  localparam logic [9:0]  BalKneeHigh      = 10'd200;
  localparam logic signed [10:0] BalStepFine   = 11'sd5;
  localparam logic signed [10:0] BalStepMid    = 11'sd10;
  localparam logic signed [10:0] BalStepCoarse = 11'sd20;

  // Divide by five: n * 13108 >> 16 is exact for n up to 1200.
  localparam logic [13:0] Div5Recip = 14'd13108;
  localparam int          Div5Shift = 16;

  typedef struct packed {
    logic signed [10:0] volume_level;
    logic signed [9:0]  balance_level;
    logic [3:0]         bass_code;
    logic [3:0]         treble_code;
    logic [1:0]         bass_freq_sel;
    logic [1:0]         treble_freq_sel;
    logic               mute_flag;
    logic [7:0]         pct_level_rb;
  } atvc_state_t;

  typedef struct packed {
    atvc_update_e update;
    atvc_state_t  levels;
  } atvc_mid_t;

endpackage

@@ rtl/core/atvc_if.sv @@
// Item channels of the audio tone and volume control mapper.
interface atvc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [2:0] control_select;
  logic [7:0] req_pct;
  logic       mute_value;

  modport source (output valid, action, control_select, req_pct, mute_value,
                  input ready);
  modport sink   (input valid, action, control_select, req_pct, mute_value,
                  output ready);
endinterface

interface atvc_out_if;
  logic              valid;
  logic              ready;
  logic [2:0]        codec_update;
  logic signed [8:0] left_volume_half_db;
  logic signed [8:0] right_volume_half_db;
  logic [3:0]        bass_gain_code;
  logic [3:0]        treble_gain_code;
  logic [1:0]        bass_freq_index;
  logic [1:0]        treble_freq_index;
  logic              mute_state;
  logic [7:0]        pct_readback;
  logic signed [9:0] balance_tenth_db;

  modport source (output valid, codec_update, left_volume_half_db, right_volume_half_db,
                  bass_gain_code, treble_gain_code, bass_freq_index, treble_freq_index,
                  mute_state, pct_readback, balance_tenth_db,
                  input ready);
  modport sink   (input valid, codec_update, left_volume_half_db, right_volume_half_db,
                  bass_gain_code, treble_gain_code, bass_freq_index, treble_freq_index,
                  mute_state, pct_readback, balance_tenth_db,
                  output ready);
endinterface

@@ rtl/core/atvc_state.sv @@
// Input register and control level update of the tone and volume mapper.
module atvc_state #(
  parameter int unsigned MAX_PCT = 200
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  atvc_in_if.sink             in_i,
  output logic                mid_valid_o,
  input  logic                mid_ready_i,
  output atvc_pkg::atvc_mid_t mid_o
);
  import atvc_pkg::*;

  localparam int PctDiv  = MAX_PCT / 10;
  localparam int RbFull  = (MAX_PCT > 255) ? 255 : MAX_PCT;
  localparam int PctSpan = 256;

  logic               item_valid_q;
  atvc_action_e       action_q;
  logic [2:0]         sel_q;
  logic [7:0]         pct_q;
  logic               mute_q;
  logic               item_ready;
  logic               advance;

  logic               mid_valid_q;
  atvc_update_e       upd_q;
  atvc_update_e       upd_d;
  atvc_state_t        st_q;
  atvc_state_t        st_d;

  logic signed [10:0] vol_rom [PctSpan];
  logic [7:0]         rb_rom  [PctSpan];

  logic               step_up;
  logic [9:0]         bal_mag;
  logic signed [10:0] bal_inc;
  logic signed [10:0] bal_sum;

  // Step a tone code; a lower code is a higher gain.
  function automatic logic [3:0] gain_code_step(input logic [3:0] code, input logic up);
    logic [3:0] res;
    res = code;
    if (up) begin
      if (code != ToneCodeBottom) res = code - 4'd1;
    end else begin
      if (code != ToneCodeTop) res = code + 4'd1;
    end
    return res;
  endfunction

  // Step a corner frequency selector within its range.
  function automatic logic [1:0] freq_step(input logic [1:0] sel, input logic up);
    logic [1:0] res;
    res = sel;
    if (up) begin
      if (sel != FreqTop) res = sel + 2'd1;
    end else begin
      if (sel != FreqBottom) res = sel - 2'd1;
    end
    return res;
  endfunction

  // Build the percent to level and level to percent tables
  for (genvar g = 0; g < PctSpan; g++) begin : g_pct_rom
    localparam int PctSat = (g > MAX_PCT) ? MAX_PCT : g;
    localparam int LvlRaw = -800 + (PctSat * 80) / PctDiv;
    localparam int Lvl    = (LvlRaw > 0) ? 0 : LvlRaw;
    localparam int RbRaw  = (MAX_PCT * (Lvl + 800)) / 800;
    localparam int Rb     = (RbRaw > 255) ? 255 : RbRaw;
    assign vol_rom[g] = 11'(Lvl);
    assign rb_rom[g]  = 8'(Rb);
  end

  // Handshake: the input register drains into the level stage
  assign item_ready = !mid_valid_q || mid_ready_i;
  assign advance    = item_valid_q && item_ready;
  assign in_i.ready = !item_valid_q || item_ready;

  // Hold the accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      action_q <= atvc_action_e'(in_i.action);
      sel_q    <= in_i.control_select;
      pct_q    <= in_i.req_pct;
      mute_q   <= in_i.mute_value;
    end
  end

  // Pick the balance step from its magnitude
  always_comb begin
    step_up = (action_q == ACT_STEP_UP);
    bal_mag = st_q.balance_level[9] ? 10'(-st_q.balance_level) : st_q.balance_level;
    if (bal_mag < BalKneeLow) begin
      bal_inc = BalStepFine;
    end else if (bal_mag < BalKneeHigh) begin
      bal_inc = BalStepMid;
    end else begin
      bal_inc = BalStepCoarse;
    end
    bal_sum = step_up ? (11'(st_q.balance_level) + bal_inc)
                      : (11'(st_q.balance_level) - bal_inc);
  end

  // Compute the levels after this item
  always_comb begin
    st_d  = st_q;
    upd_d = UPD_NONE;
    unique case (action_q)
      ACT_STEP_UP, ACT_STEP_DOWN: begin
        unique case (atvc_sel_e'(sel_q))
          SEL_BASS: begin
            st_d.bass_code = gain_code_step(st_q.bass_code, step_up);
            upd_d          = UPD_TONE_GAIN;
          end
          SEL_TREBLE: begin
            st_d.treble_code = gain_code_step(st_q.treble_code, step_up);
            upd_d            = UPD_TONE_GAIN;
          end
          SEL_BASS_FREQ: begin
            st_d.bass_freq_sel = freq_step(st_q.bass_freq_sel, step_up);
            upd_d              = UPD_TONE_FREQ;
          end
          SEL_TREBLE_FREQ: begin
            st_d.treble_freq_sel = freq_step(st_q.treble_freq_sel, step_up);
            upd_d                = UPD_TONE_FREQ;
          end
          SEL_BALANCE: begin
            if (bal_sum > BalTop) begin
              st_d.balance_level = 10'(BalTop);
            end else if (bal_sum < BalBottom) begin
              st_d.balance_level = 10'(BalBottom);
            end else begin
              st_d.balance_level = 10'(bal_sum);
            end
            upd_d = UPD_VOLUME;
          end
          default: begin
            upd_d = UPD_NONE;
          end
        endcase
      end
      ACT_SET_VOLUME: begin
        st_d.volume_level = vol_rom[pct_q];
        st_d.pct_level_rb = rb_rom[pct_q];
        upd_d             = UPD_VOLUME;
      end
      ACT_SET_MUTE: begin
        st_d.mute_flag = mute_q;
        upd_d          = UPD_MUTE;
      end
      default: begin
        upd_d = UPD_NONE;
      end
    endcase
  end

  // Advance the levels and the update code together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_valid_q           <= 1'b0;
      upd_q                 <= UPD_NONE;
      st_q.volume_level     <= '0;
      st_q.balance_level    <= '0;
      st_q.bass_code        <= BassCodeReset;
      st_q.treble_code      <= TrebleCodeReset;
      st_q.bass_freq_sel    <= BassFreqReset;
      st_q.treble_freq_sel  <= TrebleFreqReset;
      st_q.mute_flag        <= 1'b0;
      st_q.pct_level_rb     <= 8'(RbFull);
    end else begin
      if (item_ready) begin
        mid_valid_q <= item_valid_q;
      end
      if (advance) begin
        st_q  <= st_d;
        upd_q <= upd_d;
      end
    end
  end

  assign mid_valid_o   = mid_valid_q;
  assign mid_o.update  = upd_q;
  assign mid_o.levels  = st_q;

endmodule

@@ rtl/core/atvc_codec.sv @@
// Codec word computation and result register of the tone and volume mapper.
module atvc_codec (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                mid_valid_i,
  output logic                mid_ready_o,
  input  atvc_pkg::atvc_mid_t mid_i,
  atvc_out_if.source          out_o
);
  import atvc_pkg::*;

  logic signed [9:0]  bal_pos;
  logic signed [9:0]  bal_neg;
  logic signed [11:0] sum_l;
  logic signed [11:0] sum_r;
  logic [10:0]        mag_l;
  logic [10:0]        mag_r;
  logic [24:0]        prod_l;
  logic [24:0]        prod_r;
  logic [7:0]         quo_l;
  logic [7:0]         quo_r;
  logic signed [8:0]  left_d;
  logic signed [8:0]  right_d;

  logic               out_valid_q;
  atvc_update_e       upd_q;
  logic signed [8:0]  left_q;
  logic signed [8:0]  right_q;
  logic [3:0]         bass_q;
  logic [3:0]         treble_q;
  logic [1:0]         bass_freq_q;
  logic [1:0]         treble_freq_q;
  logic               mute_q;
  logic [7:0]         pct_q;
  logic [9:0]         bal_q;

  // Attenuate one side by the balance, then divide by five toward zero
  always_comb begin
    bal_pos = mid_i.levels.balance_level[9] ? 10'sd0 : mid_i.levels.balance_level;
    bal_neg = mid_i.levels.balance_level[9] ? mid_i.levels.balance_level : 10'sd0;
    sum_l   = 12'(mid_i.levels.volume_level) - 12'(bal_pos);
    sum_r   = 12'(mid_i.levels.volume_level) + 12'(bal_neg);
    mag_l   = 11'(-sum_l);
    mag_r   = 11'(-sum_r);
    prod_l  = 25'(mag_l) * 25'(Div5Recip);
    prod_r  = 25'(mag_r) * 25'(Div5Recip);
    quo_l   = prod_l[Div5Shift +: 8];
    quo_r   = prod_r[Div5Shift +: 8];
    left_d  = 9'(-$signed({1'b0, quo_l}));
    right_d = 9'(-$signed({1'b0, quo_r}));
  end

  assign mid_ready_o = !out_valid_q || out_o.ready;

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mid_ready_o) begin
      out_valid_q <= mid_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mid_valid_i && mid_ready_o) begin
      upd_q         <= mid_i.update;
      left_q        <= left_d;
      right_q       <= right_d;
      bass_q        <= mid_i.levels.bass_code;
      treble_q      <= mid_i.levels.treble_code;
      bass_freq_q   <= mid_i.levels.bass_freq_sel;
      treble_freq_q <= mid_i.levels.treble_freq_sel;
      mute_q        <= mid_i.levels.mute_flag;
      pct_q         <= mid_i.levels.pct_level_rb;
      bal_q         <= mid_i.levels.balance_level;
    end
  end

  assign out_o.valid                = out_valid_q;
  assign out_o.codec_update         = upd_q;
  assign out_o.left_volume_half_db  = left_q;
  assign out_o.right_volume_half_db = right_q;
  assign out_o.bass_gain_code       = bass_q;
  assign out_o.treble_gain_code     = treble_q;
  assign out_o.bass_freq_index      = bass_freq_q;
  assign out_o.treble_freq_index    = treble_freq_q;
  assign out_o.mute_state           = mute_q;
  assign out_o.pct_readback         = pct_q;
  assign out_o.balance_tenth_db     = bal_q;

endmodule

@@ rtl/core/audio_tone_volume_control_mapper.sv @@
// Top level of the audio tone and volume control mapper.
//
//   channel  dir  handshake      payload
//   in_i     in   valid / ready  action, control_select, req_pct, mute_value
//   out_o    out  valid / ready  codec words, mute state, percent readback, balance
//
// One item per cycle sustained while out_o.ready stays high; an accepted item
// passes through the input register, the level register and the result
// register before its result is presented.
// Reset clears all control levels to their defaults and empties every stage.
// A stalled output backs up through two buffered stages before in_i.ready drops.
`include "audio_tone_volume_control_mapper_assert.svh"

module audio_tone_volume_control_mapper #(
  parameter int unsigned MAX_PCT = 200
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  atvc_in_if.sink     in_i,
  atvc_out_if.source  out_o
);
  import atvc_pkg::*;

  logic      mid_valid;
  logic      mid_ready;
  atvc_mid_t mid;

  // Level update stage
  atvc_state #(
    .MAX_PCT (MAX_PCT)
  ) u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  // Codec word stage
  atvc_codec u_codec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .out_o       (out_o)
  );

  `ATVC_ASSERT(a_ready_when_out_empty, !out_o.valid |-> in_i.ready, "input stalled with empty output")
  `ATVC_ASSERT_NEXT(a_stall_keeps_result, !in_i.ready, out_o.valid, "stall without a held result")
  `ATVC_ASSERT(a_balance_range, out_o.valid |-> (out_o.balance_tenth_db <= 10'sd400 && out_o.balance_tenth_db >= -10'sd400), "balance out of range")
  `ATVC_ASSERT(a_balance_side, (out_o.valid && out_o.balance_tenth_db >= 10'sd0) |-> (out_o.right_volume_half_db >= out_o.left_volume_half_db), "balance cut the wrong side")

endmodule

@@ verif/tb_audio_tone_volume_control_mapper.sv @@
// Self-checking testbench for the audio tone and volume control mapper.
`timescale 1ns / 100ps

module tb_audio_tone_volume_control_mapper;
  import atvc_pkg::*;

  localparam int MaxPct        = 200;
  localparam int ToneTop       = 120;
  localparam int ToneBottom    = -105;
  localparam int ToneInc       = 15;
  localparam int BalLimit      = 400;
  localparam int BalInc        = 5;
  localparam int VolFloor      = -800;
  localparam int FreqMax       = 3;
  localparam int RandItems     = 1600;
  localparam int WatchdogLimit = 500;
  localparam int DrainCycles   = 16;
  localparam int ReportLimit   = 10;

  // Selector codes the block treats as no control at all
  localparam logic [2:0] SelSpare0 = 3'd5;
  localparam logic [2:0] SelSpare1 = 3'd6;
  localparam logic [2:0] SelSpare2 = 3'd7;

  typedef struct {
    atvc_action_e action;
    logic [2:0]   sel;
    logic [7:0]   pct;
    logic         mute;
  } ctrl_event_t;

  typedef struct {
    atvc_update_e      upd;
    logic signed [8:0] left_hdb;
    logic signed [8:0] right_hdb;
    logic [3:0]        bass_code;
    logic [3:0]        treble_code;
    logic [1:0]        bass_fidx;
    logic [1:0]        treble_fidx;
    logic              mute;
    logic [7:0]        pct_rb;
    logic signed [9:0] bal;
  } codec_words_t;

  typedef struct {
    ctrl_event_t ev;
    int          typed_idx;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  atvc_in_if  ctrl_ch ();
  atvc_out_if codec_ch ();

  audio_tone_volume_control_mapper #(
    .MAX_PCT(MaxPct)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ctrl_ch),
    .out_o (codec_ch)
  );

  // Shadow copy of the control levels
  logic signed [10:0] vol_lvl;
  logic signed [9:0]  bal_lvl;
  logic signed [7:0]  bass_lvl;
  logic signed [7:0]  treble_lvl;
  logic [1:0]         bass_fsel;
  logic [1:0]         treble_fsel;
  logic               mute_lvl;

  codec_words_t codec_words_due [$];

  int  items_sent;
  int  words_checked;
  int  mismatches;
  int  upd_seen [5];
  bit  bal_top_seen;
  bit  bal_bottom_seen;
  bit  send_idle;
  bit  recv_idle;
  int  idle_cycles;

  // Results read straight off the levels at a glance
  codec_words_t typed_words [3] = '{
    '{UPD_MUTE,   9'sd0,    9'sd0,    4'd4, 4'd6, 2'd1, 2'd0, 1'b0, 8'd200, 10'sd0},
    '{UPD_VOLUME, -9'sd160, -9'sd160, 4'd4, 4'd6, 2'd1, 2'd0, 1'b1, 8'd0,   10'sd0},
    '{UPD_TONE_GAIN, 9'sd0, 9'sd0,    4'd0, 4'd6, 2'd1, 2'd0, 1'b1, 8'd200, 10'sd0}
  };

  localparam int DirRows = 26;

  // Directed items, walked from reset in order
  dir_row_t dir_tab [DirRows] = '{
    '{'{ACT_SET_MUTE,   SEL_BASS,        8'd0,   1'b0}, 0},
    '{'{ACT_SET_MUTE,   SEL_TREBLE,      8'd0,   1'b1}, -1},
    '{'{ACT_SET_VOLUME, SEL_BASS,        8'd0,   1'b0}, 1},
    '{'{ACT_SET_VOLUME, SEL_BALANCE,     8'd255, 1'b0}, -1},
    '{'{ACT_SET_VOLUME, SelSpare2,       8'd100, 1'b1}, -1},
    '{'{ACT_SET_VOLUME, SEL_BASS,        8'd201, 1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS,        8'd255, 1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS,        8'd0,   1'b1}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS,        8'd170, 1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS,        8'd85,  1'b1}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS,        8'd0,   1'b0}, 2},
    '{'{ACT_STEP_DOWN,  SEL_TREBLE,      8'd0,   1'b0}, -1},
    '{'{ACT_STEP_DOWN,  SEL_TREBLE_FREQ, 8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS_FREQ,   8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS_FREQ,   8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BASS_FREQ,   8'd0,   1'b0}, -1},
    '{'{ACT_STEP_DOWN,  SEL_BASS_FREQ,   8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_TREBLE_FREQ, 8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SEL_BALANCE,     8'd0,   1'b0}, -1},
    '{'{ACT_STEP_DOWN,  SEL_BALANCE,     8'd0,   1'b0}, -1},
    '{'{ACT_STEP_DOWN,  SEL_BALANCE,     8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SelSpare0,       8'd0,   1'b0}, -1},
    '{'{ACT_STEP_DOWN,  SelSpare1,       8'd0,   1'b0}, -1},
    '{'{ACT_STEP_UP,    SelSpare2,       8'd255, 1'b1}, -1},
    '{'{ACT_SET_MUTE,   SelSpare2,       8'd255, 1'b0}, -1},
    '{'{ACT_SET_VOLUME, SEL_TREBLE,      8'd20,  1'b1}, -1}
  };

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Apply one control event to the shadow levels and derive the codec words
  function automatic codec_words_t compute_codec_words(ctrl_event_t ev);
    codec_words_t w;
    int           dir;
    int           mag;
    int           step;
    int           pct;
    int           lvl;
    int           vl;
    int           vr;
    int           rb;
    dir = (ev.action == ACT_STEP_UP) ? 1 : -1;
    w.upd = UPD_NONE;
    case (ev.action)
      ACT_STEP_UP, ACT_STEP_DOWN: begin
        case (ev.sel)
          SEL_BASS: begin
            bass_lvl = 8'(clamp_int(int'(bass_lvl) + dir * ToneInc, ToneBottom, ToneTop));
            w.upd = UPD_TONE_GAIN;
          end
          SEL_TREBLE: begin
            treble_lvl = 8'(clamp_int(int'(treble_lvl) + dir * ToneInc, ToneBottom, ToneTop));
            w.upd = UPD_TONE_GAIN;
          end
          SEL_BASS_FREQ: begin
            bass_fsel = 2'(clamp_int(int'(bass_fsel) + dir, 0, FreqMax));
            w.upd = UPD_TONE_FREQ;
          end
          SEL_TREBLE_FREQ: begin
            treble_fsel = 2'(clamp_int(int'(treble_fsel) + dir, 0, FreqMax));
            w.upd = UPD_TONE_FREQ;
          end
          SEL_BALANCE: begin
            // Coarser steps as the balance moves away from center
            mag = (bal_lvl < 0) ? -int'(bal_lvl) : int'(bal_lvl);
            step = (mag < 100) ? BalInc : (mag < 200) ? 2 * BalInc : 4 * BalInc;
            bal_lvl = 10'(clamp_int(int'(bal_lvl) + dir * step, -BalLimit, BalLimit));
            w.upd = UPD_VOLUME;
          end
          default: w.upd = UPD_NONE;
        endcase
      end
      ACT_SET_VOLUME: begin
        pct = int'(ev.pct);
        if (pct > MaxPct) pct = MaxPct;
        lvl = VolFloor + (pct * 80) / (MaxPct / 10);
        if (lvl > 0) lvl = 0;
        vol_lvl = 11'(lvl);
        w.upd = UPD_VOLUME;
      end
      default: begin
        mute_lvl = ev.mute;
        w.upd = UPD_MUTE;
      end
    endcase

    // Attenuate the side opposite the balance, then halve-dB units
    vl = int'(vol_lvl);
    vr = int'(vol_lvl);
    if (bal_lvl < 0) vr += int'(bal_lvl);
    else vl -= int'(bal_lvl);
    rb = (MaxPct * (int'(vol_lvl) - VolFloor)) / (-VolFloor);
    rb = clamp_int(rb, 0, 255);

    w.left_hdb    = 9'(vl / 5);
    w.right_hdb   = 9'(vr / 5);
    w.bass_code   = 4'((ToneTop - int'(bass_lvl)) / ToneInc);
    w.treble_code = 4'((ToneTop - int'(treble_lvl)) / ToneInc);
    w.bass_fidx   = bass_fsel;
    w.treble_fidx = treble_fsel;
    w.mute        = mute_lvl;
    w.pct_rb      = 8'(rb);
    w.bal         = bal_lvl;
    if (bal_lvl == BalLimit) bal_top_seen = 1'b1;
    if (bal_lvl == -BalLimit) bal_bottom_seen = 1'b1;
    return w;
  endfunction

  function automatic ctrl_event_t any_event();
    ctrl_event_t ev;
    ev.action = atvc_action_e'($urandom_range(0, 3));
    ev.sel    = 3'($urandom_range(0, 7));
    ev.pct    = 8'($urandom_range(0, 255));
    ev.mute   = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Present one item, after a random gap while send_idle is set, and hold it until accepted
  task automatic drive_item(input ctrl_event_t ev, input int typed_idx);
    int unsigned  gap;
    codec_words_t w;
    gap = send_idle ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      ctrl_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ctrl_ch.valid          <= 1'b1;
    ctrl_ch.action         <= ev.action;
    ctrl_ch.control_select <= ev.sel;
    ctrl_ch.req_pct        <= ev.pct;
    ctrl_ch.mute_value     <= ev.mute;
    do @(posedge clk_i); while (!ctrl_ch.ready);
    w = compute_codec_words(ev);
    codec_words_due.push_back((typed_idx >= 0) ? typed_words[typed_idx] : w);
    items_sent++;
    @(negedge clk_i);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_all_words();
    if (codec_words_due.size() != 0) begin
      ctrl_ch.valid <= 1'b0;
      while (codec_words_due.size() != 0) @(negedge clk_i);
    end
  endtask

  task automatic check_words(input codec_words_t got);
    codec_words_t want;
    bit           bad;
    if (codec_words_due.size() == 0) begin
      mismatches++;
      if (mismatches <= ReportLimit)
        $display("%0t: result with nothing expected: %p", $realtime, got);
    end else begin
      want = codec_words_due.pop_front();
      bad = (got.upd !== want.upd) || (got.left_hdb !== want.left_hdb) ||
            (got.right_hdb !== want.right_hdb) || (got.bass_code !== want.bass_code) ||
            (got.treble_code !== want.treble_code) || (got.bass_fidx !== want.bass_fidx) ||
            (got.treble_fidx !== want.treble_fidx) || (got.mute !== want.mute) ||
            (got.pct_rb !== want.pct_rb) || (got.bal !== want.bal);
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportLimit) begin
          $display("%0t: result %0d mismatch", $realtime, words_checked);
          $display("  expected %p", want);
          $display("  actual   %p", got);
        end
      end
      if (int'(want.upd) < 5) upd_seen[int'(want.upd)]++;
    end
    words_checked++;
  endtask

  // Result side: stall at random, take each result and check it
  initial begin
    codec_words_t got;
    int unsigned  stall;
    codec_ch.ready = 1'b0;
    recv_idle = 1'b1;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(0, 39) == 0) recv_idle = !recv_idle;
      stall = recv_idle ? $urandom_range(0, 4) : 0;
      if (stall != 0) begin
        codec_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      codec_ch.ready <= 1'b1;
      do @(posedge clk_i); while (codec_ch.valid !== 1'b1);
      got.upd         = atvc_update_e'(codec_ch.codec_update);
      got.left_hdb    = codec_ch.left_volume_half_db;
      got.right_hdb   = codec_ch.right_volume_half_db;
      got.bass_code   = codec_ch.bass_gain_code;
      got.treble_code = codec_ch.treble_gain_code;
      got.bass_fidx   = codec_ch.bass_freq_index;
      got.treble_fidx = codec_ch.treble_freq_index;
      got.mute        = codec_ch.mute_state;
      got.pct_rb      = codec_ch.pct_readback;
      got.bal         = codec_ch.balance_tenth_db;
      check_words(got);
      @(negedge clk_i);
    end
  end

  // End the run if no item moves on either side for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (ctrl_ch.valid && ctrl_ch.ready) || (codec_ch.valid && codec_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: reset, directed table, then random runs
  initial begin
    ctrl_event_t  ev;
    atvc_action_e run_act;
    logic [2:0]   run_sel;
    int unsigned  run_len;
    int unsigned  pick;
    bit           drained;
    rst_ni                 = 1'b0;
    ctrl_ch.valid          = 1'b0;
    ctrl_ch.action         = ACT_STEP_UP;
    ctrl_ch.control_select = SEL_BASS;
    ctrl_ch.req_pct        = 8'd0;
    ctrl_ch.mute_value     = 1'b0;
    idle_cycles            = 0;
    items_sent             = 0;
    words_checked          = 0;
    mismatches             = 0;
    drained                = 1'b0;
    send_idle              = 1'b1;
    vol_lvl                = 11'sd0;
    bal_lvl                = 10'sd0;
    bass_lvl               = 8'sd60;
    treble_lvl             = 8'sd30;
    bass_fsel              = 2'd1;
    treble_fsel            = 2'd0;
    mute_lvl               = 1'b0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int r = 0; r < DirRows; r++) drive_item(dir_tab[r].ev, dir_tab[r].typed_idx);
    wait_all_words();

    while (items_sent < DirRows + RandItems) begin
      if (!drained && items_sent >= DirRows + RandItems / 2) begin
        wait_all_words();
        drained = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) send_idle = !send_idle;
      pick = $urandom_range(0, 9);
      if (pick <= 5) begin
        // Run of steps on one control, long enough now and then to hit a limit
        run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 8);
        run_sel = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
        run_act = ($urandom_range(0, 1) != 0) ? ACT_STEP_UP : ACT_STEP_DOWN;
        repeat (run_len) begin
          ev = any_event();
          ev.action = run_act;
          ev.sel = run_sel;
          drive_item(ev, -1);
        end
      end else if (pick <= 7) begin
        ev = any_event();
        ev.action = ACT_SET_VOLUME;
        if ($urandom_range(0, 3) == 0) begin
          case ($urandom_range(0, 3))
            0:       ev.pct = 8'd0;
            1:       ev.pct = 8'(MaxPct);
            2:       ev.pct = 8'(MaxPct + 1);
            default: ev.pct = 8'd255;
          endcase
        end
        drive_item(ev, -1);
      end else if (pick == 8) begin
        ev = any_event();
        ev.action = ACT_SET_MUTE;
        drive_item(ev, -1);
      end else begin
        drive_item(any_event(), -1);
      end
    end
    ctrl_ch.valid <= 1'b0;

    while (codec_words_due.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d control events (%0d from the directed table), checked %0d results",
             items_sent, DirRows, words_checked);
    $display("Updates none/mute/gain/freq/volume: %0d/%0d/%0d/%0d/%0d, balance at +/-%0d: %0b/%0b",
             upd_seen[0], upd_seen[1], upd_seen[2], upd_seen[3], upd_seen[4], BalLimit,
             bal_top_seen, bal_bottom_seen);
    if (mismatches == 0 && codec_words_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
